// ===== sv/lsp_pkg.sv =====
// Shared widths, register indexes, reset values, item op codes and the command
// and status types that pass between the letterbox mapper controller and its datapath.
// Depends on nothing.
`default_nettype none

package lsp_pkg;

  localparam int COORD_BITS = 13;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int SURF_BITS  = 12;
  localparam int ALIGN_BITS = 8;

  localparam int DVSR_BITS    = (SIZE_BITS > SURF_BITS) ? SIZE_BITS : SURF_BITS;
  localparam int PROD_BITS    = SIZE_BITS + SURF_BITS;
  localparam int DIV_STEPS    = PROD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = SURF_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_ALIGN     = 2'd2;

  localparam logic OP_RESIZE = 1'b0;
  localparam logic OP_MAP    = 1'b1;

  localparam logic [SURF_BITS-1:0]  SURFACE_WIDTH_RESET  = 12'd640;
  localparam logic [SURF_BITS-1:0]  SURFACE_HEIGHT_RESET = 12'd480;
  localparam logic [ALIGN_BITS-1:0] SIZE_ALIGN_RESET     = 8'd4;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_FIT_MUL1,
    DP_FIT_MUL2,
    DP_FIT_DIV,
    DP_ALIGN_W,
    DP_ALIGN_H,
    DP_COMMIT,
    DP_CLIP,
    DP_MULX,
    DP_DIVX,
    DP_MULY,
    DP_DIVY,
    DP_MAP_END,
    DP_EMIT
  } dp_step_t;

  typedef struct packed {
    logic     capture;
    dp_step_t step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/lsp_div.sv =====
// Restoring divider that produces one quotient bit per cycle, shared by all
// divisions of the letterbox mapper. Depends on lsp_pkg.
`default_nettype none

module lsp_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lsp_pkg::PROD_BITS-1:0]  dividend,
  input  wire logic [lsp_pkg::DVSR_BITS-1:0]  divisor,
  output logic                                busy,
  output logic [lsp_pkg::PROD_BITS-1:0]       quot,
  output logic [lsp_pkg::DVSR_BITS-1:0]       rem
);

  logic [lsp_pkg::DVSR_BITS-1:0]    dvsr;
  logic [lsp_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [lsp_pkg::DVSR_BITS:0]      shifted;
  logic [lsp_pkg::DVSR_BITS:0]      diff;
  logic                             ge;

  assign shifted = {rem, quot[lsp_pkg::PROD_BITS-1]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == lsp_pkg::DIV_CNT_BITS'(lsp_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[lsp_pkg::PROD_BITS-2:0], ge};
      rem  <= ge ? diff[lsp_pkg::DVSR_BITS-1:0] : shifted[lsp_pkg::DVSR_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lsp_datapath.sv =====
// Datapath of the letterbox mapper: configuration registers, stored draw area,
// shared multiplier, clip logic, divider and output register.
// Depends on lsp_pkg and lsp_div.
`default_nettype none

module lsp_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lsp_pkg::ctrl_cmd_t                     cmd,
  output lsp_pkg::dp_status_t                         status,
  input  wire logic                                   cfg_we,
  input  wire logic [lsp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [lsp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  in_x,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  in_y,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic [lsp_pkg::SURF_BITS-1:0]               surf_x,
  output logic [lsp_pkg::SURF_BITS-1:0]               surf_y,
  output logic                                        clipped,
  output logic signed [lsp_pkg::COORD_BITS-1:0]       area_left,
  output logic signed [lsp_pkg::COORD_BITS-1:0]       area_top,
  output logic [lsp_pkg::SIZE_BITS-1:0]               area_width,
  output logic [lsp_pkg::SIZE_BITS-1:0]               area_height
);

  logic [lsp_pkg::SURF_BITS-1:0]  surface_width;
  logic [lsp_pkg::SURF_BITS-1:0]  surface_height;
  logic [lsp_pkg::ALIGN_BITS-1:0] size_align;

  logic signed [lsp_pkg::COORD_BITS-1:0] area_left_reg;
  logic signed [lsp_pkg::COORD_BITS-1:0] area_top_reg;
  logic [lsp_pkg::SIZE_BITS-1:0]         area_width_reg;
  logic [lsp_pkg::SIZE_BITS-1:0]         area_height_reg;

  logic signed [lsp_pkg::COORD_BITS-1:0] px;
  logic signed [lsp_pkg::COORD_BITS-1:0] py;
  logic [lsp_pkg::PROD_BITS-1:0]         prod_a;
  logic [lsp_pkg::PROD_BITS-1:0]         prod_b;
  logic                                  fit_le;
  logic [lsp_pkg::SIZE_BITS-1:0]         nw;
  logic [lsp_pkg::SIZE_BITS-1:0]         nh;
  logic [lsp_pkg::SIZE_BITS-1:0]         dx;
  logic [lsp_pkg::SIZE_BITS-1:0]         dy;
  logic                                  clip;
  logic [lsp_pkg::SURF_BITS-1:0]         sx;
  logic [lsp_pkg::SURF_BITS-1:0]         sy;

  logic [lsp_pkg::SIZE_BITS-1:0]  win_w;
  logic [lsp_pkg::SIZE_BITS-1:0]  win_h;
  logic [lsp_pkg::SURF_BITS-1:0]  sw_eff;
  logic [lsp_pkg::SURF_BITS-1:0]  sh_eff;
  logic [lsp_pkg::ALIGN_BITS-1:0] al_eff;
  logic [lsp_pkg::SIZE_BITS-1:0]  mul_a;
  logic [lsp_pkg::SURF_BITS-1:0]  mul_b;
  logic [lsp_pkg::PROD_BITS-1:0]  mul_p;
  logic                           div_start;
  logic [lsp_pkg::PROD_BITS-1:0]  div_dividend;
  logic [lsp_pkg::DVSR_BITS-1:0]  div_divisor;
  logic                           div_busy;
  logic [lsp_pkg::PROD_BITS-1:0]  quot;
  logic [lsp_pkg::DVSR_BITS-1:0]  rem;
  logic                           fit_le_now;
  logic [lsp_pkg::SIZE_BITS-1:0]  nw_fit;
  logic [lsp_pkg::SIZE_BITS-1:0]  nh_fit;
  logic [lsp_pkg::SIZE_BITS-1:0]  rem_s;
  logic [lsp_pkg::SIZE_BITS-1:0]  nh_fin;
  logic [lsp_pkg::SIZE_BITS-1:0]  dw;
  logic [lsp_pkg::SIZE_BITS-1:0]  dh;
  logic [lsp_pkg::DVSR_BITS-1:0]  aw_eff;
  logic [lsp_pkg::DVSR_BITS-1:0]  ah_eff;
  logic [lsp_pkg::SIZE_BITS-1:0]  dx_next;
  logic [lsp_pkg::SIZE_BITS-1:0]  dy_next;
  logic                           clip_x;
  logic                           clip_y;
  logic                           out_free;

  // Clamping one axis: below the start gives offset zero, at or beyond the end
  // gives the last pixel of the area, or zero when the area is empty.
  function automatic logic [lsp_pkg::SIZE_BITS:0] clamp_axis(
    input logic signed [lsp_pkg::COORD_BITS-1:0] p,
    input logic signed [lsp_pkg::COORD_BITS-1:0] start,
    input logic [lsp_pkg::SIZE_BITS-1:0]         size
  );
    logic signed [lsp_pkg::COORD_BITS:0] p_e;
    logic signed [lsp_pkg::COORD_BITS:0] s_e;
    logic signed [lsp_pkg::COORD_BITS:0] e_e;
    logic signed [lsp_pkg::COORD_BITS:0] d_e;
    logic                                lo;
    logic                                hi;
    logic [lsp_pkg::SIZE_BITS-1:0]       d;
    p_e = {p[lsp_pkg::COORD_BITS-1], p};
    s_e = {start[lsp_pkg::COORD_BITS-1], start};
    e_e = s_e + $signed({2'b00, size});
    d_e = p_e - s_e;
    lo  = p_e < s_e;
    hi  = p_e >= e_e;
    if (lo) begin
      d = '0;
    end else if (hi) begin
      d = (size == '0) ? '0 : size - 1'b1;
    end else begin
      d = d_e[lsp_pkg::SIZE_BITS-1:0];
    end
    return {lo | hi, d};
  endfunction

  assign win_w = px[lsp_pkg::COORD_BITS-1] ? '0 : px[lsp_pkg::SIZE_BITS-1:0];
  assign win_h = py[lsp_pkg::COORD_BITS-1] ? '0 : py[lsp_pkg::SIZE_BITS-1:0];

  assign sw_eff = (surface_width == '0) ? lsp_pkg::SURF_BITS'(1) : surface_width;
  assign sh_eff = (surface_height == '0) ? lsp_pkg::SURF_BITS'(1) : surface_height;
  assign al_eff = (size_align == '0) ? lsp_pkg::ALIGN_BITS'(1) : size_align;
  assign aw_eff = (area_width_reg == '0) ? lsp_pkg::DVSR_BITS'(1)
                                         : lsp_pkg::DVSR_BITS'(area_width_reg);
  assign ah_eff = (area_height_reg == '0) ? lsp_pkg::DVSR_BITS'(1)
                                          : lsp_pkg::DVSR_BITS'(area_height_reg);

  assign fit_le_now = prod_a <= prod_b;
  assign nw_fit     = fit_le ? win_w : quot[lsp_pkg::SIZE_BITS-1:0];
  assign nh_fit     = fit_le ? quot[lsp_pkg::SIZE_BITS-1:0] : win_h;
  assign rem_s      = rem[lsp_pkg::SIZE_BITS-1:0];
  assign nh_fin     = nh - rem_s;
  assign dw         = win_w - nw;
  assign dh         = win_h - nh_fin;

  assign {clip_x, dx_next} = clamp_axis(px, area_left_reg, area_width_reg);
  assign {clip_y, dy_next} = clamp_axis(py, area_top_reg, area_height_reg);

  assign mul_p = lsp_pkg::PROD_BITS'(mul_a) * lsp_pkg::PROD_BITS'(mul_b);

  always_comb begin
    mul_a        = dx;
    mul_b        = surface_width;
    div_start    = 1'b0;
    div_dividend = prod_a;
    div_divisor  = aw_eff;
    unique case (cmd.step)
      lsp_pkg::DP_FIT_MUL1: begin
        mul_a = win_w;
        mul_b = sh_eff;
      end
      lsp_pkg::DP_FIT_MUL2: begin
        mul_a = win_h;
        mul_b = sw_eff;
      end
      lsp_pkg::DP_FIT_DIV: begin
        div_start    = 1'b1;
        div_dividend = fit_le_now ? prod_a : prod_b;
        div_divisor  = fit_le_now ? lsp_pkg::DVSR_BITS'(sw_eff)
                                  : lsp_pkg::DVSR_BITS'(sh_eff);
      end
      lsp_pkg::DP_ALIGN_W: begin
        div_start    = 1'b1;
        div_dividend = lsp_pkg::PROD_BITS'(nw_fit);
        div_divisor  = lsp_pkg::DVSR_BITS'(al_eff);
      end
      lsp_pkg::DP_ALIGN_H: begin
        div_start    = 1'b1;
        div_dividend = lsp_pkg::PROD_BITS'(nh);
        div_divisor  = lsp_pkg::DVSR_BITS'(al_eff);
      end
      lsp_pkg::DP_MULX: begin
        mul_a = dx;
        mul_b = surface_width;
      end
      lsp_pkg::DP_DIVX: begin
        div_start   = 1'b1;
        div_divisor = aw_eff;
      end
      lsp_pkg::DP_MULY: begin
        mul_a = dy;
        mul_b = surface_height;
      end
      lsp_pkg::DP_DIVY: begin
        div_start   = 1'b1;
        div_divisor = ah_eff;
      end
      default: begin
      end
    endcase
  end

  lsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign out_free        = !out_valid || !out_stall;
  assign status.div_busy = div_busy;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width   <= lsp_pkg::SURFACE_WIDTH_RESET;
      surface_height  <= lsp_pkg::SURFACE_HEIGHT_RESET;
      size_align      <= lsp_pkg::SIZE_ALIGN_RESET;
      area_left_reg   <= '0;
      area_top_reg    <= '0;
      area_width_reg  <= lsp_pkg::SIZE_BITS'(lsp_pkg::SURFACE_WIDTH_RESET);
      area_height_reg <= lsp_pkg::SIZE_BITS'(lsp_pkg::SURFACE_HEIGHT_RESET);
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lsp_pkg::REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
          lsp_pkg::REG_SURFACE_HEIGHT: surface_height <= cfg_data;
          lsp_pkg::REG_SIZE_ALIGN:     size_align     <= cfg_data[lsp_pkg::ALIGN_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.step == lsp_pkg::DP_COMMIT) begin
        area_width_reg  <= nw;
        area_height_reg <= nh_fin;
        area_left_reg   <= {2'b00, dw[lsp_pkg::SIZE_BITS-1:1]};
        area_top_reg    <= {2'b00, dh[lsp_pkg::SIZE_BITS-1:1]};
      end
      if (cmd.step == lsp_pkg::DP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px   <= in_x;
      py   <= in_y;
      sx   <= '0;
      sy   <= '0;
      clip <= 1'b0;
    end
    unique case (cmd.step)
      lsp_pkg::DP_FIT_MUL1: prod_a <= mul_p;
      lsp_pkg::DP_FIT_MUL2: prod_b <= mul_p;
      lsp_pkg::DP_FIT_DIV:  fit_le <= fit_le_now;
      lsp_pkg::DP_ALIGN_W: begin
        nw <= nw_fit;
        nh <= nh_fit;
      end
      lsp_pkg::DP_ALIGN_H:  nw <= nw - rem_s;
      lsp_pkg::DP_CLIP: begin
        dx   <= dx_next;
        dy   <= dy_next;
        clip <= clip_x | clip_y;
      end
      lsp_pkg::DP_MULX:     prod_a <= mul_p;
      lsp_pkg::DP_MULY: begin
        sx     <= quot[lsp_pkg::SURF_BITS-1:0];
        prod_a <= mul_p;
      end
      lsp_pkg::DP_MAP_END:  sy <= quot[lsp_pkg::SURF_BITS-1:0];
      lsp_pkg::DP_EMIT: begin
        if (out_free) begin
          surf_x      <= sx;
          surf_y      <= sy;
          clipped     <= clip;
          area_left   <= area_left_reg;
          area_top    <= area_top_reg;
          area_width  <= area_width_reg;
          area_height <= area_height_reg;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lsp_ctrl.sv =====
// Controller of the letterbox mapper: a one-hot state machine that sequences
// the datapath through resize and map items. Depends on lsp_pkg.
`default_nettype none

module lsp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 op,
  input  wire lsp_pkg::dp_status_t  status,
  output lsp_pkg::ctrl_cmd_t        cmd,
  output logic                      in_stall
);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_FIT_MUL1  = 19'h00002,
    S_FIT_MUL2  = 19'h00004,
    S_FIT_DIV   = 19'h00008,
    S_FIT_WAIT  = 19'h00010,
    S_ALIGN_W   = 19'h00020,
    S_ALW_WAIT  = 19'h00040,
    S_ALIGN_H   = 19'h00080,
    S_ALH_WAIT  = 19'h00100,
    S_COMMIT    = 19'h00200,
    S_CLIP      = 19'h00400,
    S_MULX      = 19'h00800,
    S_DIVX      = 19'h01000,
    S_DIVX_WAIT = 19'h02000,
    S_MULY      = 19'h04000,
    S_DIVY      = 19'h08000,
    S_DIVY_WAIT = 19'h10000,
    S_MAP_END   = 19'h20000,
    S_EMIT      = 19'h40000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = in_valid && (state == S_IDLE);
    cmd.step    = lsp_pkg::DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (op == lsp_pkg::OP_MAP) ? S_CLIP : S_FIT_MUL1;
        end
      end
      S_FIT_MUL1: begin
        cmd.step   = lsp_pkg::DP_FIT_MUL1;
        state_next = S_FIT_MUL2;
      end
      S_FIT_MUL2: begin
        cmd.step   = lsp_pkg::DP_FIT_MUL2;
        state_next = S_FIT_DIV;
      end
      S_FIT_DIV: begin
        cmd.step   = lsp_pkg::DP_FIT_DIV;
        state_next = S_FIT_WAIT;
      end
      S_FIT_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_ALIGN_W;
        end
      end
      S_ALIGN_W: begin
        cmd.step   = lsp_pkg::DP_ALIGN_W;
        state_next = S_ALW_WAIT;
      end
      S_ALW_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_ALIGN_H;
        end
      end
      S_ALIGN_H: begin
        cmd.step   = lsp_pkg::DP_ALIGN_H;
        state_next = S_ALH_WAIT;
      end
      S_ALH_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.step   = lsp_pkg::DP_COMMIT;
        state_next = S_EMIT;
      end
      S_CLIP: begin
        cmd.step   = lsp_pkg::DP_CLIP;
        state_next = S_MULX;
      end
      S_MULX: begin
        cmd.step   = lsp_pkg::DP_MULX;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        cmd.step   = lsp_pkg::DP_DIVX;
        state_next = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_MULY;
        end
      end
      S_MULY: begin
        cmd.step   = lsp_pkg::DP_MULY;
        state_next = S_DIVY;
      end
      S_DIVY: begin
        cmd.step   = lsp_pkg::DP_DIVY;
        state_next = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_MAP_END;
        end
      end
      S_MAP_END: begin
        cmd.step   = lsp_pkg::DP_MAP_END;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.step = lsp_pkg::DP_EMIT;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/letterbox_scaler_point_mapper.sv =====
// Letterbox scaler point mapper, top level: controller plus datapath.
// Depends on lsp_pkg, lsp_ctrl and lsp_datapath.
//
// The block handles one item at a time and gives one result per item. All
// divisions run on one shared restoring divider that yields one quotient bit
// per cycle, and the controller waits in a wait state until the divider is no
// longer busy. A resize item does three divisions (aspect fit, then rounding
// of width and of height); a map item does two divisions (x and y scaling).
// The next item can be accepted in the cycle after the result is loaded, and
// a result that is held off stalls the next item at its last step. in_stall
// is low whenever no item is in progress, even while a finished result still
// waits in the output register. Writing the surface size does not move the
// stored draw area until the next resize item or reset.
`default_nettype none

module letterbox_scaler_point_mapper (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [lsp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [lsp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   op,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  in_x,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  in_y,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [lsp_pkg::SURF_BITS-1:0]               surf_x,
  output logic [lsp_pkg::SURF_BITS-1:0]               surf_y,
  output logic                                        clipped,
  output logic signed [lsp_pkg::COORD_BITS-1:0]       area_left,
  output logic signed [lsp_pkg::COORD_BITS-1:0]       area_top,
  output logic [lsp_pkg::SIZE_BITS-1:0]               area_width,
  output logic [lsp_pkg::SIZE_BITS-1:0]               area_height
);

  lsp_pkg::ctrl_cmd_t  cmd;
  lsp_pkg::dp_status_t status;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lsp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_x        (in_x),
    .in_y        (in_y),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .surf_x      (surf_x),
    .surf_y      (surf_y),
    .clipped     (clipped),
    .area_left   (area_left),
    .area_top    (area_top),
    .area_width  (area_width),
    .area_height (area_height)
  );

endmodule

`default_nettype wire

// ===== test/lsp_mapping_checker.sv =====
// Scoreboard for the letterbox scaler point mapper: it watches the register port and both
// item channels, keeps its own copy of the draw area and compares every result field by field.
// Depends on lsp_pkg.
module lsp_mapping_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [lsp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [lsp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_stall,
  input  wire logic                                   op,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  in_x,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  in_y,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_stall,
  input  wire logic [lsp_pkg::SURF_BITS-1:0]          surf_x,
  input  wire logic [lsp_pkg::SURF_BITS-1:0]          surf_y,
  input  wire logic                                   clipped,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  area_left,
  input  wire logic signed [lsp_pkg::COORD_BITS-1:0]  area_top,
  input  wire logic [lsp_pkg::SIZE_BITS-1:0]          area_width,
  input  wire logic [lsp_pkg::SIZE_BITS-1:0]          area_height,
  output int                                          fail_count,
  output int                                          outstanding,
  output int                                          checked_count,
  output int                                          clip_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsp_pkg::*;

  localparam int   MAX_REPORTS = 10;

  typedef struct packed {
    logic [SURF_BITS-1:0]  sx;
    logic [SURF_BITS-1:0]  sy;
    logic                  clip;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [SIZE_BITS-1:0]  width;
    logic [SIZE_BITS-1:0]  height;
  } mapped_point_t;

  logic [SURF_BITS-1:0]  surf_w_cfg;
  logic [SURF_BITS-1:0]  surf_h_cfg;
  logic [ALIGN_BITS-1:0] align_cfg;
  int area_x0, area_y0, area_w, area_h;
  mapped_point_t expected_points[$];

  function automatic int nonzero(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int scale_to_surface(input int p, input int start, input int size,
                                          input int surf);
    int q, d;
    q = p;
    if (q < start) q = start;
    if (start + size <= q) q = start + size - 1;
    d = q - start;
    if (d < 0) d = 0;
    return (d * surf) / nonzero(size);
  endfunction

  function automatic mapped_point_t next_result(input logic op_bit,
                                                input logic signed [COORD_BITS-1:0] px,
                                                input logic signed [COORD_BITS-1:0] py);
    mapped_point_t r;
    int x, y, w, h, sw, sh, al, nw, nh;
    r = '0;
    x = px;
    y = py;
    if (op_bit == OP_RESIZE) begin
      w = (x < 0) ? 0 : x;
      h = (y < 0) ? 0 : y;
      sw = nonzero(int'(surf_w_cfg));
      sh = nonzero(int'(surf_h_cfg));
      al = nonzero(int'(align_cfg));
      if (w * sh <= h * sw) begin
        nw = w;
        nh = (sh * w) / sw;
      end else begin
        nh = h;
        nw = (sw * h) / sh;
      end
      nw = (nw / al) * al;
      nh = (nh / al) * al;
      area_x0 = (w - nw) / 2;
      area_y0 = (h - nh) / 2;
      area_w = nw & ((1 << SIZE_BITS) - 1);
      area_h = nh & ((1 << SIZE_BITS) - 1);
    end else begin
      r.sx = SURF_BITS'(scale_to_surface(x, area_x0, area_w, int'(surf_w_cfg)));
      r.sy = SURF_BITS'(scale_to_surface(y, area_y0, area_h, int'(surf_h_cfg)));
      r.clip = (x < area_x0) || (x >= area_x0 + area_w) ||
               (y < area_y0) || (y >= area_y0 + area_h);
    end
    r.left = area_x0[COORD_BITS-1:0];
    r.top = area_y0[COORD_BITS-1:0];
    r.width = area_w[SIZE_BITS-1:0];
    r.height = area_h[SIZE_BITS-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [COORD_BITS-1:0] want,
                             input logic [COORD_BITS-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("result %0d, %s: expected 0x%h, got 0x%h", checked_count, field, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    mapped_point_t want;
    if (rst) begin
      surf_w_cfg = SURFACE_WIDTH_RESET;
      surf_h_cfg = SURFACE_HEIGHT_RESET;
      align_cfg = SIZE_ALIGN_RESET;
      area_x0 = 0;
      area_y0 = 0;
      area_w = surf_w_cfg;
      area_h = surf_h_cfg;
      expected_points.delete();
      fail_count = 0;
      checked_count = 0;
      clip_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_SURFACE_WIDTH: surf_w_cfg = cfg_data;
          REG_SURFACE_HEIGHT: surf_h_cfg = cfg_data;
          REG_SIZE_ALIGN: align_cfg = cfg_data[ALIGN_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_points.push_back(next_result(op, in_x, in_y));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result with no item pending: surf_x=%0d surf_y=%0d clipped=%b",
                     surf_x, surf_y, clipped);
        end else begin
          want = expected_points.pop_front();
          check_field("surf_x", want.sx, surf_x);
          check_field("surf_y", want.sy, surf_y);
          check_field("clipped", want.clip, clipped);
          check_field("area_left", want.left, area_left);
          check_field("area_top", want.top, area_top);
          check_field("area_width", want.width, area_width);
          check_field("area_height", want.height, area_height);
          if (want.clip) clip_count++;
          checked_count++;
        end
      end
      outstanding <= expected_points.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Top of the letterbox scaler point mapper testbench: clock, reset, register setup and
// item stimulus with random idling on both channels, and the verdict.
// Depends on lsp_pkg, letterbox_scaler_point_mapper and lsp_mapping_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsp_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES     = 800;
  localparam int TAIL_CYCLES     = 150;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 120;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          op = OP_RESIZE;
  logic signed [COORD_BITS-1:0]  in_x = '0;
  logic signed [COORD_BITS-1:0]  in_y = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [SURF_BITS-1:0]          surf_x;
  logic [SURF_BITS-1:0]          surf_y;
  logic                          clipped;
  logic signed [COORD_BITS-1:0]  area_left;
  logic signed [COORD_BITS-1:0]  area_top;
  logic [SIZE_BITS-1:0]          area_width;
  logic [SIZE_BITS-1:0]          area_height;
  int fail_count, outstanding, checked_count, clip_count;

  int items_sent = 0;
  int resize_count = 0;
  int settings_count = 0;
  int win_w = 640;
  int win_h = 480;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_request = 1'b0;
  int holds_done = 0;

  letterbox_scaler_point_mapper dut (.*);
  lsp_mapping_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : result_sink
    int n;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end
      n = receiver_idle ? $urandom_range(0, 11) : 0;
      out_stall <= (n != 0);
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (n != 0) begin
        repeat (n - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic kind, input int x, input int y);
    int gap;
    gap = sender_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    in_x <= x[COORD_BITS-1:0];
    in_y <= y[COORD_BITS-1:0];
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    if (kind == OP_RESIZE) begin
      resize_count++;
      win_w = (x < 0) ? 0 : x;
      win_h = (y < 0) ? 0 : y;
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_regs(input int sw, input int sh, input int al);
    cfg_we <= 1'b1;
    cfg_index <= REG_SURFACE_WIDTH;
    cfg_data <= sw[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_index <= REG_SURFACE_HEIGHT;
    cfg_data <= sh[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_index <= REG_SIZE_ALIGN;
    cfg_data <= al[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Most points land in or just around the current window, the rest anywhere.
  task automatic send_map();
    int x, y;
    if ($urandom_range(0, 9) < 7) begin
      x = int'($urandom_range(0, win_w + 8)) - 4;
      y = int'($urandom_range(0, win_h + 8)) - 4;
      if (x > 4095) x = 4095;
      if (y > 4095) y = 4095;
    end else begin
      x = int'($urandom_range(0, 8191)) - 4096;
      y = int'($urandom_range(0, 8191)) - 4096;
    end
    send_item(OP_MAP, x, y);
  endtask

  task automatic send_resize();
    int r, w, h;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      w = $urandom_range(1, 4095);
      h = $urandom_range(1, 4095);
    end else if (r < 8) begin
      w = $urandom_range(0, 64);
      h = $urandom_range(0, 64);
    end else begin
      w = int'($urandom_range(0, 8191)) - 4096;
      h = int'($urandom_range(0, 8191)) - 4096;
    end
    send_item(OP_RESIZE, w, h);
  endtask

  initial begin : stimulus
    int sw, sh, al;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset draw area first, then fitting, repeats, negative and tiny windows.
    send_item(OP_MAP, 0, 0);
    send_item(OP_MAP, 639, 479);
    send_item(OP_MAP, 640, 480);
    send_item(OP_MAP, -4096, -4096);
    send_item(OP_MAP, 4095, 4095);
    send_item(OP_MAP, 320, -1);
    send_item(OP_RESIZE, 800, 600);
    send_item(OP_RESIZE, 800, 600);
    send_item(OP_MAP, 400, 300);
    send_item(OP_RESIZE, 1920, 1080);
    send_item(OP_MAP, 0, 540);
    send_item(OP_MAP, 1919, 0);
    send_item(OP_RESIZE, 1000, 1000);
    send_item(OP_MAP, 500, 1000);
    send_item(OP_RESIZE, -1, 500);
    send_item(OP_MAP, 5, 5);
    send_item(OP_MAP, -4096, 4095);
    send_item(OP_RESIZE, 4095, -4096);
    send_item(OP_MAP, 0, 0);
    send_item(OP_RESIZE, 3, 3);
    send_item(OP_MAP, 1, 1);
    send_item(OP_RESIZE, 4095, 4095);
    send_item(OP_MAP, 2047, 2047);
    send_item(OP_RESIZE, 641, 481);
    send_item(OP_MAP, 4095, -4096);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0: begin sw = 1; sh = 1; al = 1; end
        1: begin sw = 4095; sh = 4095; al = 255; end
        2: begin sw = 0; sh = 0; al = 0; end
        3: begin sw = 4095; sh = 1; al = 1; end
        4: begin sw = 1; sh = 4095; al = 2; end
        5: begin sw = 640; sh = 480; al = 4; end
        default: begin
          sw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4095);
          sh = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4095);
          al = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(0, 255);
        end
      endcase
      // The upper bits of the write data are unused by the alignment register.
      program_regs(sw, sh, ($urandom_range(0, 15) << 8) | al);
      sender_idle = (phase != 5) && ($urandom_range(0, 3) != 0);
      receiver_idle = (phase != 5) && ($urandom_range(0, 3) != 0);
      if (phase == 6) hold_request = 1'b1;
      // Three points against the old draw area, scaled to the new surface size.
      repeat (3) send_map();
      repeat (ITEMS_PER_PHASE - 3) begin
        if ($urandom_range(0, 4) == 0) send_resize();
        else send_map();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d items (%0d resizes) over %0d register settings plus reset values",
             items_sent, resize_count, settings_count);
    $display("summary: %0d results compared, %0d clipped, %0d long output hold-offs",
             checked_count, clip_count, holds_done);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
